// ===== design/rv32d_pkg.sv =====
// Shared constants for the RV32I decoder: opcodes, mnemonic codes and format codes.
// Depends on nothing; imported by the decoder top level.
package rv32d_pkg;

  // Major opcodes, bits 6:0 of the word.
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Instruction format codes.
  localparam logic [2:0] FMT_R = 3'd0;
  localparam logic [2:0] FMT_I = 3'd1;
  localparam logic [2:0] FMT_S = 3'd2;
  localparam logic [2:0] FMT_B = 3'd3;
  localparam logic [2:0] FMT_U = 3'd4;
  localparam logic [2:0] FMT_J = 3'd5;

  // Dense mnemonic codes; zero means the word is not recognized.
  localparam logic [5:0] MN_UNKNOWN = 6'd0;
  localparam logic [5:0] MN_LUI     = 6'd1;
  localparam logic [5:0] MN_AUIPC   = 6'd2;
  localparam logic [5:0] MN_JAL     = 6'd3;
  localparam logic [5:0] MN_JALR    = 6'd4;
  localparam logic [5:0] MN_BEQ     = 6'd5;
  localparam logic [5:0] MN_BNE     = 6'd6;
  localparam logic [5:0] MN_BLT     = 6'd7;
  localparam logic [5:0] MN_BGE     = 6'd8;
  localparam logic [5:0] MN_BLTU    = 6'd9;
  localparam logic [5:0] MN_BGEU    = 6'd10;
  localparam logic [5:0] MN_LB      = 6'd11;
  localparam logic [5:0] MN_LH      = 6'd12;
  localparam logic [5:0] MN_LW      = 6'd13;
  localparam logic [5:0] MN_LBU     = 6'd14;
  localparam logic [5:0] MN_LHU     = 6'd15;
  localparam logic [5:0] MN_SB      = 6'd16;
  localparam logic [5:0] MN_SH      = 6'd17;
  localparam logic [5:0] MN_SW      = 6'd18;
  localparam logic [5:0] MN_ADDI    = 6'd19;
  localparam logic [5:0] MN_SLTI    = 6'd20;
  localparam logic [5:0] MN_SLTIU   = 6'd21;
  localparam logic [5:0] MN_XORI    = 6'd22;
  localparam logic [5:0] MN_ORI     = 6'd23;
  localparam logic [5:0] MN_ANDI    = 6'd24;
  localparam logic [5:0] MN_SLLI    = 6'd25;
  localparam logic [5:0] MN_SRLI    = 6'd26;
  localparam logic [5:0] MN_SRAI    = 6'd27;
  localparam logic [5:0] MN_ADD     = 6'd28;
  localparam logic [5:0] MN_SUB     = 6'd29;
  localparam logic [5:0] MN_SLL     = 6'd30;
  localparam logic [5:0] MN_SLT     = 6'd31;
  localparam logic [5:0] MN_SLTU    = 6'd32;
  localparam logic [5:0] MN_XOR     = 6'd33;
  localparam logic [5:0] MN_SRL     = 6'd34;
  localparam logic [5:0] MN_SRA     = 6'd35;
  localparam logic [5:0] MN_OR      = 6'd36;
  localparam logic [5:0] MN_AND     = 6'd37;
  localparam logic [5:0] MN_FENCE   = 6'd38;
  localparam logic [5:0] MN_FENCE_I = 6'd39;
  localparam logic [5:0] MN_ECALL   = 6'd40;
  localparam logic [5:0] MN_EBREAK  = 6'd41;
  localparam logic [5:0] MN_CSRRW   = 6'd42;
  localparam logic [5:0] MN_CSRRS   = 6'd43;
  localparam logic [5:0] MN_CSRRC   = 6'd44;

  // Opcode class found in the first stage.
  typedef enum logic [3:0] {
    CLS_NONE,
    CLS_LUI,
    CLS_AUIPC,
    CLS_JAL,
    CLS_JALR,
    CLS_BRANCH,
    CLS_LOAD,
    CLS_STORE,
    CLS_OP_IMM,
    CLS_OP,
    CLS_FENCE,
    CLS_SYSTEM
  } op_class_t;

endpackage

// ===== design/rv32i_instruction_decoder.sv =====
// RV32I instruction decoder: three-stage pipeline from instruction word to decoded fields.
// Depends on rv32d_pkg for opcodes, mnemonic codes and format codes.
// Throughput: one word per cycle when the output is not stalled; each stage holds one word
// and moves as soon as the stage after it is empty or draining, so a stall at the output
// loses and repeats nothing.
// Reset (synchronous, active high) clears the three stage valid bits; payload is not reset.
module rv32i_instruction_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        instruction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         mnemonic,
  output logic [2:0]         format_kind,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src1_reg,
  output logic [4:0]         src2_reg,
  output logic signed [31:0] immediate,
  output logic [11:0]        csr_address
);
  import rv32d_pkg::*;

  // Stage 1 holds the word and its opcode class.
  // Stage 2 holds the word, the mnemonic and the format.
  // Stage 3 is the output register with the selected immediate.
  logic        v1;
  logic        v2;
  logic        v3;
  logic [31:0] word1;
  logic [31:0] word2;
  op_class_t   cls1;
  op_class_t   cls_next;
  logic [5:0]  mn2;
  logic [2:0]  fmt2;
  logic [5:0]  mn_next;
  logic [2:0]  fmt_next;
  logic [31:0] imm_next;

  logic adv1;
  logic adv2;
  logic adv3;

  // A stage may load when it is empty or when its own word moves on in this cycle.
  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign out_valid = v3;

  // Stage 1: classify the major opcode.
  always_comb begin
    case (instruction[6:0])
      OPC_LUI:    cls_next = CLS_LUI;
      OPC_AUIPC:  cls_next = CLS_AUIPC;
      OPC_JAL:    cls_next = CLS_JAL;
      OPC_JALR:   cls_next = CLS_JALR;
      OPC_BRANCH: cls_next = CLS_BRANCH;
      OPC_LOAD:   cls_next = CLS_LOAD;
      OPC_STORE:  cls_next = CLS_STORE;
      OPC_OP_IMM: cls_next = CLS_OP_IMM;
      OPC_OP:     cls_next = CLS_OP;
      OPC_FENCE:  cls_next = CLS_FENCE;
      OPC_SYSTEM: cls_next = CLS_SYSTEM;
      default:    cls_next = CLS_NONE;
    endcase
  end

  // Stage 2: resolve funct3, funct7 and the system fields into a mnemonic.
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic        sys_zero;
  logic [11:0] csr_f;

  assign f3       = word1[14:12];
  assign f7       = word1[31:25];
  assign csr_f    = word1[31:20];
  assign sys_zero = (word1[11:7] == 5'd0) && (word1[19:15] == 5'd0);

  always_comb begin
    mn_next = MN_UNKNOWN;
    case (cls1)
      CLS_LUI:   mn_next = MN_LUI;
      CLS_AUIPC: mn_next = MN_AUIPC;
      CLS_JAL:   mn_next = MN_JAL;
      CLS_JALR:  mn_next = (f3 == 3'd0) ? MN_JALR : MN_UNKNOWN;
      CLS_BRANCH: begin
        case (f3)
          3'd0:    mn_next = MN_BEQ;
          3'd1:    mn_next = MN_BNE;
          3'd4:    mn_next = MN_BLT;
          3'd5:    mn_next = MN_BGE;
          3'd6:    mn_next = MN_BLTU;
          3'd7:    mn_next = MN_BGEU;
          default: mn_next = MN_UNKNOWN;
        endcase
      end
      CLS_LOAD: begin
        case (f3)
          3'd0:    mn_next = MN_LB;
          3'd1:    mn_next = MN_LH;
          3'd2:    mn_next = MN_LW;
          3'd4:    mn_next = MN_LBU;
          3'd5:    mn_next = MN_LHU;
          default: mn_next = MN_UNKNOWN;
        endcase
      end
      CLS_STORE: begin
        case (f3)
          3'd0:    mn_next = MN_SB;
          3'd1:    mn_next = MN_SH;
          3'd2:    mn_next = MN_SW;
          default: mn_next = MN_UNKNOWN;
        endcase
      end
      CLS_OP_IMM: begin
        case (f3)
          3'd0:    mn_next = MN_ADDI;
          3'd1:    mn_next = (f7 == F7_ZERO) ? MN_SLLI : MN_UNKNOWN;
          3'd2:    mn_next = MN_SLTI;
          3'd3:    mn_next = MN_SLTIU;
          3'd4:    mn_next = MN_XORI;
          3'd5: begin
            if (f7 == F7_ZERO) mn_next = MN_SRLI;
            else if (f7 == F7_ALT) mn_next = MN_SRAI;
            else mn_next = MN_UNKNOWN;
          end
          3'd6:    mn_next = MN_ORI;
          default: mn_next = MN_ANDI;
        endcase
      end
      CLS_OP: begin
        if (f7 == F7_ZERO) begin
          case (f3)
            3'd0:    mn_next = MN_ADD;
            3'd1:    mn_next = MN_SLL;
            3'd2:    mn_next = MN_SLT;
            3'd3:    mn_next = MN_SLTU;
            3'd4:    mn_next = MN_XOR;
            3'd5:    mn_next = MN_SRL;
            3'd6:    mn_next = MN_OR;
            default: mn_next = MN_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) mn_next = MN_SUB;
          else if (f3 == 3'd5) mn_next = MN_SRA;
          else mn_next = MN_UNKNOWN;
        end
      end
      CLS_FENCE: begin
        if (f3 == 3'd0) mn_next = MN_FENCE;
        else if (f3 == 3'd1) mn_next = MN_FENCE_I;
        else mn_next = MN_UNKNOWN;
      end
      CLS_SYSTEM: begin
        case (f3)
          3'd0: begin
            if (sys_zero && csr_f == 12'd0) mn_next = MN_ECALL;
            else if (sys_zero && csr_f == 12'd1) mn_next = MN_EBREAK;
            else mn_next = MN_UNKNOWN;
          end
          3'd1:    mn_next = MN_CSRRW;
          3'd2:    mn_next = MN_CSRRS;
          3'd3:    mn_next = MN_CSRRC;
          default: mn_next = MN_UNKNOWN;
        endcase
      end
      default: mn_next = MN_UNKNOWN;
    endcase
  end

  // An unrecognized word reports the R format, which also zeroes its immediate.
  always_comb begin
    case (cls1)
      CLS_LUI, CLS_AUIPC: fmt_next = FMT_U;
      CLS_JAL:            fmt_next = FMT_J;
      CLS_BRANCH:         fmt_next = FMT_B;
      CLS_STORE:          fmt_next = FMT_S;
      CLS_OP, CLS_NONE:   fmt_next = FMT_R;
      default:            fmt_next = FMT_I;
    endcase
    if (mn_next == MN_UNKNOWN) fmt_next = FMT_R;
  end

  // Stage 3: assemble the immediate of the format.
  always_comb begin
    case (fmt2)
      FMT_I:   imm_next = {{20{word2[31]}}, word2[31:20]};
      FMT_S:   imm_next = {{20{word2[31]}}, word2[31:25], word2[11:7]};
      FMT_B:   imm_next = {{20{word2[31]}}, word2[7], word2[30:25], word2[11:8], 1'b0};
      FMT_U:   imm_next = {word2[31:12], 12'd0};
      FMT_J:   imm_next = {{12{word2[31]}}, word2[19:12], word2[20], word2[30:21], 1'b0};
      default: imm_next = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1 && in_valid) begin
      word1 <= instruction;
      cls1  <= cls_next;
    end
    if (adv2 && v1) begin
      word2 <= word1;
      mn2   <= mn_next;
      fmt2  <= fmt_next;
    end
    if (adv3 && v2) begin
      mnemonic    <= mn2;
      format_kind <= fmt2;
      dest_reg    <= word2[11:7];
      src1_reg    <= word2[19:15];
      src2_reg    <= word2[24:20];
      immediate   <= imm_next;
      csr_address <= word2[31:20];
    end
  end

endmodule
